FILE: rtl/lgdf_pkg.sv
// ----------------------------------------------------------------------------
// lgdf_pkg
// Shared types and constants of the LED pad store with change tracking.
// ----------------------------------------------------------------------------
package lgdf_pkg;

	localparam logic [1:0] KIND_SET_PALETTE = 2'd0;
	localparam logic [1:0] KIND_SET_RGB     = 2'd1;
	localparam logic [1:0] KIND_SET_MODE    = 2'd2;
	localparam logic [1:0] KIND_FLUSH       = 2'd3;

	localparam logic [1:0] MODE_STATIC = 2'd0;
	localparam logic [1:0] MODE_PULSE  = 2'd2;

	localparam logic [7:0] NOTE_STATUS_BASE = 8'h90;
	localparam logic [7:0] BULK_SPEC_RGB    = 8'h03;
	localparam logic [2:0] REC_LEN_RGB      = 3'd5;
	localparam logic [2:0] REC_LEN_SHORT    = 3'd3;
	localparam logic [6:0] PAD_NUM_BASE     = 7'd11;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] col;
		logic [2:0] row;
		logic [6:0] palette_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [1:0] light_mode;
	} in_word_t;

	typedef struct packed {
		logic       bulk_form;
		logic       first_record;
		logic       last_record;
		logic [2:0] byte_count;
		logic [7:0] byte_a;
		logic [6:0] byte_b;
		logic [6:0] byte_c;
		logic [6:0] byte_d;
		logic [6:0] byte_e;
	} out_word_t;

	typedef struct packed {
		logic [6:0] palette;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       rgb;
		logic [1:0] mode;
	} pad_t;

endpackage

FILE: rtl/led_grid_diff_flush.sv
// ----------------------------------------------------------------------------
// led_grid_diff_flush
// 8x8 LED pad store with dirty tracking; a flush streams one record per
// changed pad in row-major order, in bulk or note-on form.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A set word first reads
// the pad from the store, then compares it and writes it back. A flush with
// the link down leaves the block idle and sends nothing. Otherwise a flush
// takes the word, scans the store and counts the dirty pads, then, if any is
// dirty, reads it again and sends; one read a cycle from the pad memory sets
// both passes. Records leave at most one per cycle during the second pass,
// each on result for one cycle with result_valid high; the receiver cannot
// hold them off and must take every record as it comes.
module led_grid_diff_flush #(
	parameter int BULK_THRESHOLD = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 start,
	input  lgdf_pkg::in_word_t   cmd,
	output logic                 busy,
	output logic                 result_valid,
	output lgdf_pkg::out_word_t  result
);
	import lgdf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET,
		ST_CNT,
		ST_CNT_END,
		ST_SEND,
		ST_SEND_END
	} state_t;

	state_t      state_q;
	logic        link_q;
	in_word_t    cmd_q;
	logic [63:0] valid_q;
	logic [63:0] dirty_q;
	logic [5:0]  scan_q;
	logic [6:0]  count_q;
	logic [6:0]  sent_q;
	logic        any_rgb_q;
	logic        bulk_q;

	pad_t        mem [64];
	pad_t        rd_data_s1;
	logic [5:0]  idx_s1;
	logic        rd_pv_s1;
	logic        proc_s1;

	logic [5:0]  mem_ra;
	logic        mem_we;
	pad_t        cur;
	pad_t        new_pad;
	logic        set_change;
	logic [1:0]  mode_in;
	logic        pad_dirty_s1;
	logic [6:0]  cnt_next;
	logic        rgb_next;
	logic        rec_rgb;
	logic [6:0]  pad_num;
	out_word_t   rec;

	assign busy   = (state_q != ST_IDLE);
	assign mem_ra = (state_q == ST_IDLE) ? {cmd.row, cmd.col} : scan_q;
	assign cur    = rd_pv_s1 ? rd_data_s1 : '0;

	assign pad_dirty_s1 = dirty_q[idx_s1];
	assign cnt_next     = count_q + 7'(pad_dirty_s1);
	assign rgb_next     = any_rgb_q | (pad_dirty_s1 & cur.rgb);

	always_comb begin
		mode_in    = (cmd_q.light_mode > MODE_PULSE) ? MODE_PULSE : cmd_q.light_mode;
		new_pad    = cur;
		set_change = 1'b0;
		unique case (cmd_q.kind)
			KIND_SET_PALETTE: begin
				set_change = cur.rgb || (cur.palette != cmd_q.palette_index) ||
				             (cur.mode != MODE_STATIC);
				new_pad         = '0;
				new_pad.palette = cmd_q.palette_index;
			end
			KIND_SET_RGB: begin
				set_change = !cur.rgb || (cur.red != cmd_q.red) ||
				             (cur.green != cmd_q.green) || (cur.blue != cmd_q.blue);
				new_pad       = '0;
				new_pad.red   = cmd_q.red;
				new_pad.green = cmd_q.green;
				new_pad.blue  = cmd_q.blue;
				new_pad.rgb   = 1'b1;
			end
			KIND_SET_MODE: begin
				set_change   = (cur.mode != mode_in);
				new_pad.mode = mode_in;
			end
			default: begin
				set_change = 1'b0;
			end
		endcase
	end

	assign mem_we = (state_q == ST_SET) && set_change;

	always_comb begin
		rec_rgb = bulk_q && cur.rgb;
		pad_num = 7'({idx_s1[5:3], 3'b000}) + 7'({idx_s1[5:3], 1'b0}) +
		          7'(idx_s1[2:0]) + PAD_NUM_BASE;
		rec.bulk_form    = bulk_q;
		rec.first_record = (sent_q == 7'd0);
		rec.last_record  = ((sent_q + 7'd1) == count_q);
		rec.byte_count   = rec_rgb ? REC_LEN_RGB : REC_LEN_SHORT;
		if (!bulk_q) begin
			rec.byte_a = NOTE_STATUS_BASE + 8'(cur.mode);
		end else if (cur.rgb) begin
			rec.byte_a = BULK_SPEC_RGB;
		end else begin
			rec.byte_a = 8'(cur.mode);
		end
		rec.byte_b = pad_num;
		rec.byte_c = rec_rgb ? cur.red[7:1] : cur.palette;
		rec.byte_d = rec_rgb ? cur.green[7:1] : 7'd0;
		rec.byte_e = rec_rgb ? cur.blue[7:1] : 7'd0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_s1] <= new_pad;
		end
		rd_data_s1 <= mem[mem_ra];
		if (state_q != ST_SET) begin
			idx_s1 <= mem_ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			link_q       <= 1'b0;
			valid_q      <= '0;
			dirty_q      <= '0;
			scan_q       <= '0;
			count_q      <= '0;
			sent_q       <= '0;
			any_rgb_q    <= 1'b0;
			bulk_q       <= 1'b0;
			rd_pv_s1     <= 1'b0;
			proc_s1      <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
			cmd_q        <= '0;
		end else begin
			result_valid <= 1'b0;
			rd_pv_s1     <= valid_q[mem_ra];
			proc_s1      <= 1'b0;
			if (cfg_we) begin
				link_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						if (cmd.kind != KIND_FLUSH) begin
							state_q <= ST_SET;
						end else if (link_q) begin
							state_q   <= ST_CNT;
							scan_q    <= '0;
							count_q   <= '0;
							any_rgb_q <= 1'b0;
						end
					end
				end
				ST_SET: begin
					if (set_change) begin
						valid_q[idx_s1] <= 1'b1;
						dirty_q[idx_s1] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_CNT: begin
					proc_s1 <= 1'b1;
					scan_q  <= scan_q + 6'd1;
					if (proc_s1) begin
						count_q   <= cnt_next;
						any_rgb_q <= rgb_next;
					end
					if (scan_q == 6'd63) begin
						state_q <= ST_CNT_END;
					end
				end
				ST_CNT_END: begin
					count_q <= cnt_next;
					bulk_q  <= rgb_next || (cnt_next >= 7'(BULK_THRESHOLD));
					sent_q  <= '0;
					scan_q  <= '0;
					state_q <= (cnt_next == 7'd0) ? ST_IDLE : ST_SEND;
				end
				ST_SEND, ST_SEND_END: begin
					if (proc_s1 && pad_dirty_s1) begin
						result_valid    <= 1'b1;
						result          <= rec;
						sent_q          <= sent_q + 7'd1;
						dirty_q[idx_s1] <= 1'b0;
					end
					if (state_q == ST_SEND) begin
						proc_s1 <= 1'b1;
						scan_q  <= scan_q + 6'd1;
						if (scan_q == 6'd63) begin
							state_q <= ST_SEND_END;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/lgdf_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lgdf_check
// Watches the command and record channels of the LED pad store, keeps its own
// copy of the pads, dirty bits and link flag, works out the records of every
// flush and compares each record leaving the block with the oldest one due.
// ----------------------------------------------------------------------------
module lgdf_check #(
	parameter int BULK_THRESHOLD = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 start,
	input  logic                 busy,
	input  lgdf_pkg::in_word_t   cmd,
	input  logic                 result_valid,
	input  lgdf_pkg::out_word_t  result,
	output int                   fail_count,
	output int                   pending
);
	import lgdf_pkg::*;

	pad_t        pad_mirror [64];
	logic [63:0] dirty_mirror;
	logic        link_up;
	out_word_t   records_due [$];
	out_word_t   due;

	task automatic report_mismatch(input string msg);
		if (fail_count < 100) $display("%0t ns: mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic queue_flush_records();
		int        dirty_total;
		int        n;
		logic      any_rgb;
		logic      bulk;
		pad_t      p;
		out_word_t rec;
		dirty_total = 0;
		n = 0;
		any_rgb = 1'b0;
		if (!link_up) return;
		for (int i = 0; i < 64; i++) begin
			if (dirty_mirror[i]) begin
				dirty_total++;
				if (pad_mirror[i].rgb) any_rgb = 1'b1;
			end
		end
		if (dirty_total == 0) return;
		bulk = any_rgb || dirty_total >= BULK_THRESHOLD;
		for (int i = 0; i < 64; i++) begin
			if (!dirty_mirror[i]) continue;
			p = pad_mirror[i];
			rec.bulk_form    = bulk;
			rec.first_record = (n == 0);
			rec.last_record  = (n + 1 == dirty_total);
			rec.byte_count   = REC_LEN_SHORT;
			rec.byte_a       = bulk ? {6'd0, p.mode} : NOTE_STATUS_BASE + p.mode;
			rec.byte_b       = PAD_NUM_BASE + 7'((i / 8) * 10) + 7'(i % 8);
			rec.byte_c       = p.palette;
			rec.byte_d       = 7'd0;
			rec.byte_e       = 7'd0;
			if (bulk && p.rgb) begin
				rec.byte_count = REC_LEN_RGB;
				rec.byte_a     = BULK_SPEC_RGB;
				rec.byte_c     = p.red[7:1];
				rec.byte_d     = p.green[7:1];
				rec.byte_e     = p.blue[7:1];
			end
			records_due.push_back(rec);
			n++;
			dirty_mirror[i] = 1'b0;
		end
	endtask

	task automatic take_word(input in_word_t w);
		logic [5:0] idx;
		logic [1:0] m;
		pad_t       p;
		idx = {w.row, w.col};
		p = pad_mirror[idx];
		case (w.kind)
		KIND_SET_PALETTE: begin
			if (p.rgb || p.palette != w.palette_index || p.mode != MODE_STATIC) begin
				pad_mirror[idx] = '{palette: w.palette_index, red: 8'd0, green: 8'd0,
					blue: 8'd0, rgb: 1'b0, mode: MODE_STATIC};
				dirty_mirror[idx] = 1'b1;
			end
		end
		KIND_SET_RGB: begin
			if (!p.rgb || p.red != w.red || p.green != w.green || p.blue != w.blue) begin
				pad_mirror[idx] = '{palette: 7'd0, red: w.red, green: w.green,
					blue: w.blue, rgb: 1'b1, mode: MODE_STATIC};
				dirty_mirror[idx] = 1'b1;
			end
		end
		KIND_SET_MODE: begin
			m = (w.light_mode > MODE_PULSE) ? MODE_PULSE : w.light_mode;
			if (p.mode != m) begin
				pad_mirror[idx].mode = m;
				dirty_mirror[idx] = 1'b1;
			end
		end
		KIND_FLUSH: begin
			queue_flush_records();
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 64; i++) pad_mirror[i] = '0;
			dirty_mirror = '0;
			link_up = 1'b0;
			records_due.delete();
			pending = 0;
		end else begin
			if (cfg_we) link_up = cfg_wdata;
			if (result_valid) begin
				if (records_due.size() == 0) begin
					report_mismatch("record with none expected");
				end else begin
					due = records_due.pop_front();
					check_field("bulk_form", result.bulk_form, due.bulk_form);
					check_field("first_record", result.first_record, due.first_record);
					check_field("last_record", result.last_record, due.last_record);
					check_field("byte_count", result.byte_count, due.byte_count);
					check_field("byte_a", result.byte_a, due.byte_a);
					check_field("byte_b", result.byte_b, due.byte_b);
					check_field("byte_c", result.byte_c, due.byte_c);
					check_field("byte_d", result.byte_d, due.byte_d);
					check_field("byte_e", result.byte_e, due.byte_e);
				end
			end
			if (start && !busy) take_word(cmd);
			pending = records_due.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives set and flush words into the LED pad store: a directed opening on
// the no-change, mode and form rules, then phases of random set bursts
// closed by flushes, with the link toggled between phases and random gaps.
// ----------------------------------------------------------------------------
module testbench;
	import lgdf_pkg::*;

	localparam int         RUN_LIMIT     = 400000;
	localparam int         SETTLE_CYCLES = 140;
	localparam int         PHASE_WORDS   = 78;
	localparam bit [4:0]   LINK_PLAN     = 5'b11101;
	localparam logic [1:0] MODE_FLASH    = 2'd1;
	localparam logic [1:0] MODE_CODE_3   = 2'd3;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      start = 1'b0;
	in_word_t  cmd = '0;
	logic      busy;
	logic      result_valid;
	out_word_t result;
	int        fail_count;
	int        pending;
	int        cycle_count = 0;
	bit        steady = 1'b0;

	led_grid_diff_flush #(
		.BULK_THRESHOLD(8)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.result_valid(result_valid),
		.result(result)
	);

	lgdf_check #(
		.BULK_THRESHOLD(8)
	) pad_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.result_valid(result_valid),
		.result(result),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic in_word_t random_word();
		in_word_t w;
		w.kind          = KIND_FLUSH;
		w.col           = 3'($urandom_range(0, 7));
		w.row           = 3'($urandom_range(0, 7));
		w.palette_index = 7'($urandom_range(0, 127));
		w.red           = 8'($urandom_range(0, 255));
		w.green         = 8'($urandom_range(0, 255));
		w.blue          = 8'($urandom_range(0, 255));
		w.light_mode    = 2'($urandom_range(0, 3));
		return w;
	endfunction

	function automatic in_word_t flush_word();
		in_word_t w;
		w = random_word();
		w.kind = KIND_FLUSH;
		return w;
	endfunction

	function automatic in_word_t palette_word(input int r, input int c, input int pal);
		in_word_t w;
		w = random_word();
		w.kind = KIND_SET_PALETTE;
		w.row = 3'(r);
		w.col = 3'(c);
		w.palette_index = 7'(pal);
		return w;
	endfunction

	function automatic in_word_t rgb_word(input int r, input int c, input logic [7:0] red,
		input logic [7:0] green, input logic [7:0] blue);
		in_word_t w;
		w = random_word();
		w.kind = KIND_SET_RGB;
		w.row = 3'(r);
		w.col = 3'(c);
		w.red = red;
		w.green = green;
		w.blue = blue;
		return w;
	endfunction

	function automatic in_word_t mode_word(input int r, input int c, input logic [1:0] m);
		in_word_t w;
		w = random_word();
		w.kind = KIND_SET_MODE;
		w.row = 3'(r);
		w.col = 3'(c);
		w.light_mode = m;
		return w;
	endfunction

	function automatic in_word_t random_set();
		in_word_t w;
		int       pick;
		w = random_word();
		pick = $urandom_range(0, 2);
		w.kind = (pick == 0) ? KIND_SET_PALETTE : (pick == 1) ? KIND_SET_RGB : KIND_SET_MODE;
		// crowd a few pads so that repeated values hit the no-change path
		if ($urandom_range(0, 1)) begin
			w.row = 3'($urandom_range(0, 1));
			w.col = 3'($urandom_range(0, 1));
		end
		if ($urandom_range(0, 1)) w.palette_index = $urandom_range(0, 1) ? 7'd127 : 7'd0;
		if ($urandom_range(0, 1)) begin
			w.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			w.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			w.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return w;
	endfunction

	task automatic issue(input in_word_t w);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= w;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (busy || pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_link(input logic v);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		in_word_t w;
		int       phase_words;
		int       n;
		int       pick;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// link down: flush sends nothing and keeps the dirty pad
		issue(palette_word(0, 0, 127));
		issue(flush_word());
		drain();
		write_link(1'b1);
		issue(flush_word());
		issue(flush_word());
		issue(palette_word(7, 7, 0));
		issue(palette_word(7, 7, 5));
		issue(mode_word(7, 7, MODE_FLASH));
		issue(mode_word(3, 3, MODE_CODE_3));
		issue(mode_word(1, 1, MODE_STATIC));
		issue(flush_word());
		issue(rgb_word(0, 7, 8'hFF, 8'hFF, 8'hFF));
		issue(rgb_word(7, 0, 8'h00, 8'h00, 8'h00));
		issue(mode_word(7, 0, MODE_PULSE));
		issue(rgb_word(0, 7, 8'hFF, 8'hFF, 8'hFF));
		issue(palette_word(2, 2, 1));
		issue(flush_word());
		// eight palette pads: bulk by count alone
		issue(palette_word(7, 0, 0));
		for (int k = 0; k < 7; k++) issue(palette_word(5, k, k + 1));
		issue(flush_word());

		for (int ph = 0; ph < 5; ph++) begin
			drain();
			write_link(LINK_PLAN[ph]);
			steady = (ph == 2 || ph == 4);
			phase_words = 0;
			if (ph == 3) begin
				for (int k = 0; k < 64; k++) begin
					w = random_word();
					w.kind = KIND_SET_RGB;
					w.row = 3'(k / 8);
					w.col = 3'(k % 8);
					issue(w);
				end
				issue(flush_word());
			end
			while (phase_words < PHASE_WORDS) begin
				pick = $urandom_range(0, 9);
				n = (pick < 6) ? $urandom_range(1, 7) : (pick < 9) ? $urandom_range(8, 20) : 0;
				repeat (n) begin
					issue(random_set());
					phase_words++;
				end
				issue(flush_word());
				phase_words++;
			end
		end

		drain();
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
